// ===== rtl/rol_pkg.sv =====
// Package for the recency-ordered preset list.
// Holds the word types, field widths and operation codes; no dependencies.
`timescale 1ns / 1ps

package rol_pkg;

    localparam int SLOT_W   = 3;
    localparam int SEC_W    = 20;
    localparam int ICON_W   = 8;
    localparam int MEL_W    = 8;
    localparam int COUNT_W  = 4;

    typedef enum logic [1:0] {
        OP_REMEMBER = 2'd0,
        OP_REPLACE  = 2'd1,
        OP_DELETE   = 2'd2,
        OP_READ     = 2'd3
    } t_op;

    typedef enum logic {
        ST_DONE      = 1'b0,
        ST_BAD_SLOT  = 1'b1
    } t_status;

    // One stored list entry.
    typedef struct packed {
        logic [SEC_W-1:0]  seconds;
        logic [ICON_W-1:0] icon;
        logic [MEL_W-1:0]  melody;
    } t_entry;

    // Input word.
    typedef struct packed {
        t_op               operation;
        logic [SLOT_W-1:0] slot_index;
        logic [SEC_W-1:0]  entry_seconds;
        logic [ICON_W-1:0] entry_icon;
        logic [MEL_W-1:0]  entry_melody;
    } t_in_word;

    // Result word.
    typedef struct packed {
        t_status            status;
        logic               was_present;
        logic [COUNT_W-1:0] stored_count;
        logic [SEC_W-1:0]   read_seconds;
        logic [ICON_W-1:0]  read_icon;
        logic [MEL_W-1:0]   read_melody;
    } t_out_word;

endpackage

// ===== rtl/rol_if.sv =====
// Valid/ready channel interfaces for the preset list.
// Depends on rol_pkg for the input and result word types.
`timescale 1ns / 1ps

interface rol_in_if;
    import rol_pkg::*;
    logic     valid;
    logic     ready;
    t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rol_out_if;
    import rol_pkg::*;
    logic      valid;
    logic      ready;
    t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/rol_mem.sv =====
// Entry storage for the preset list: one write port, one registered read port.
// Depends on rol_pkg for the entry type.
`timescale 1ns / 1ps

module rol_mem #(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  rol_pkg::t_entry i_wdata,
    input  logic            i_re,
    input  logic [AW-1:0]   i_raddr,
    output rol_pkg::t_entry o_rdata
);
    import rol_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/recency_ordered_preset_list_unit.sv =====
// Recency-ordered preset list: sequencer over one entry memory and one key comparator.
// Remember searches the list, shifts entries down and writes the front entry; delete shifts
// later entries up; replace writes in place; read waits on the registered read port.
// One word in flight at a time, limited by the single read and single write port.
// Reset (i_rst_n low, synchronous) empties the list and drops any pending result.
// Depends on rol_pkg, rol_if and rol_mem.
`timescale 1ns / 1ps

module recency_ordered_preset_list_unit #(
    parameter int LIST_DEPTH = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rol_in_if.sink    i_in,
    rol_out_if.source o_out
);
    import rol_pkg::*;

    localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int XW = CW + SLOT_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_MOVE,
        S_TAIL,
        S_FRONT,
        S_RDWAIT,
        S_RESULT
    } t_state;

    t_state          r_state;
    t_op             r_op;
    t_entry          r_key;
    t_entry          r_front;
    logic [CW-1:0]   r_cnt;
    logic [CW-1:0]   r_src;
    logic [CW-1:0]   r_last;
    logic            r_up;
    logic [CW-1:0]   r_cptr;
    logic            r_cv;
    logic            r_wpend;
    logic [IW-1:0]   r_wdst;
    t_status         r_status;
    logic            r_present;
    t_entry          r_rd;
    logic            r_ovalid;
    t_out_word       r_odata;

    logic            mem_we;
    logic [IW-1:0]   mem_waddr;
    t_entry          mem_wdata;
    logic            mem_re;
    logic [IW-1:0]   mem_raddr;
    t_entry          mem_rdata;

    logic            accept;
    logic [XW-1:0]   slot_x;
    logic [XW-1:0]   cnt_x;
    logic            slot_ok;
    logic            key_hit;
    logic            search_end;
    logic [CW-1:0]   miss_cnt;
    logic [CW+3:0]   cnt_out_x;
    t_entry          in_entry;

    rol_mem #(
        .DEPTH (LIST_DEPTH),
        .AW    (IW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Handshake and decode of the incoming word.
    assign i_in.ready  = (r_state == S_IDLE);
    assign accept      = i_in.valid && i_in.ready;
    assign slot_x      = XW'(i_in.data.slot_index);
    assign cnt_x       = XW'(r_cnt);
    assign slot_ok     = (slot_x < cnt_x);
    assign in_entry    = '{seconds: i_in.data.entry_seconds,
                           icon:    i_in.data.entry_icon,
                           melody:  i_in.data.entry_melody};

    // Shared key comparator; it sees one stored entry per cycle during the search.
    assign key_hit    = r_cv && (mem_rdata.seconds == r_key.seconds)
                             && (mem_rdata.icon == r_key.icon);
    assign search_end = r_cv && (r_cptr == r_cnt - CW'(1));
    assign miss_cnt   = (r_cnt < DEPTH_C) ? (r_cnt + CW'(1)) : r_cnt;
    assign cnt_out_x  = (CW + 4)'(r_cnt);

    // Memory port control.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_wdst;
        mem_wdata = mem_rdata;
        mem_re    = 1'b0;
        mem_raddr = r_src[IW-1:0];
        unique case (r_state)
            S_IDLE: begin
                mem_raddr = slot_x[IW-1:0];
                mem_waddr = slot_x[IW-1:0];
                mem_wdata = in_entry;
                mem_re    = accept && (i_in.data.operation == OP_READ) && slot_ok;
                mem_we    = accept && (i_in.data.operation == OP_REPLACE) && slot_ok;
            end
            S_SEARCH: begin
                mem_re = (r_src < r_cnt);
            end
            S_MOVE: begin
                mem_re = 1'b1;
                mem_we = r_wpend;
            end
            S_TAIL: begin
                mem_we = r_wpend;
            end
            S_FRONT: begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = r_front;
            end
            S_RDWAIT, S_RESULT: begin
            end
            default: begin
            end
        endcase
    end

    // Sequencer and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_cv     <= 1'b0;
            r_wpend  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            // A taken result is cleared unless a new one is loaded this cycle.
            if (o_out.ready && (r_state != S_RESULT)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_op      <= i_in.data.operation;
                        r_key     <= in_entry;
                        r_status  <= ((i_in.data.operation != OP_REMEMBER) && !slot_ok) ?
                                     ST_BAD_SLOT : ST_DONE;
                        r_present <= 1'b0;
                        r_rd      <= '0;
                        r_cv      <= 1'b0;
                        r_wpend   <= 1'b0;
                        if (i_in.data.operation == OP_REMEMBER) begin
                            if (r_cnt == '0) begin
                                r_cnt   <= CW'(1);
                                r_front <= in_entry;
                                r_state <= S_FRONT;
                            end else begin
                                r_src   <= '0;
                                r_state <= S_SEARCH;
                            end
                        end else if (!slot_ok) begin
                            r_state  <= S_RESULT;
                        end else begin
                            unique case (i_in.data.operation)
                                OP_REPLACE: r_state <= S_RESULT;
                                OP_READ:    r_state <= S_RDWAIT;
                                OP_DELETE: begin
                                    // Close the gap by moving later entries up one place.
                                    if ((slot_x + XW'(1)) < cnt_x) begin
                                        r_src   <= CW'(slot_x + XW'(1));
                                        r_last  <= r_cnt - CW'(1);
                                        r_up    <= 1'b1;
                                        r_state <= S_MOVE;
                                    end else begin
                                        r_state <= S_TAIL;
                                    end
                                end
                                default: r_state <= S_RESULT;
                            endcase
                        end
                    end
                end
                S_SEARCH: begin
                    if (key_hit) begin
                        r_present <= 1'b1;
                        r_front   <= '{seconds: mem_rdata.seconds,
                                       icon:    mem_rdata.icon,
                                       melody:  r_key.melody};
                        r_cv      <= 1'b0;
                        if (r_cptr == '0) begin
                            r_state <= S_FRONT;
                        end else begin
                            r_src   <= r_cptr - CW'(1);
                            r_last  <= '0;
                            r_up    <= 1'b0;
                            r_state <= S_MOVE;
                        end
                    end else if (search_end) begin
                        // Miss: new entry goes to the front, the oldest may fall off.
                        r_cnt   <= miss_cnt;
                        r_front <= r_key;
                        r_cv    <= 1'b0;
                        if (miss_cnt == CW'(1)) begin
                            r_state <= S_FRONT;
                        end else begin
                            r_src   <= miss_cnt - CW'(2);
                            r_last  <= '0;
                            r_up    <= 1'b0;
                            r_state <= S_MOVE;
                        end
                    end else begin
                        r_cv   <= (r_src < r_cnt);
                        r_cptr <= r_src;
                        r_src  <= r_src + CW'(1);
                    end
                end
                S_MOVE: begin
                    // Read one entry per cycle; it is written in the next cycle.
                    r_wpend <= 1'b1;
                    r_wdst  <= r_up ? IW'(r_src - CW'(1)) : IW'(r_src + CW'(1));
                    if (r_src == r_last) begin
                        r_state <= S_TAIL;
                    end else if (r_up) begin
                        r_src <= r_src + CW'(1);
                    end else begin
                        r_src <= r_src - CW'(1);
                    end
                end
                S_TAIL: begin
                    r_wpend <= 1'b0;
                    if (r_op == OP_DELETE) begin
                        r_cnt   <= r_cnt - CW'(1);
                        r_state <= S_RESULT;
                    end else begin
                        r_state <= S_FRONT;
                    end
                end
                S_FRONT: begin
                    r_state <= S_RESULT;
                end
                S_RDWAIT: begin
                    r_rd    <= mem_rdata;
                    r_state <= S_RESULT;
                end
                S_RESULT: begin
                    if (!r_ovalid || o_out.ready) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= '{status:       r_status,
                                      was_present:  r_present,
                                      stored_count: cnt_out_x[COUNT_W-1:0],
                                      read_seconds: r_rd.seconds,
                                      read_icon:    r_rd.icon,
                                      read_melody:  r_rd.melody};
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_odata;

endmodule

// ===== sim/preset_list_checker.sv =====
// Checker for the recency-ordered preset list: watches both channels, keeps its own
// copy of the list and compares every result word. Depends on rol_pkg and rol_if.
`timescale 1ns / 1ps

module preset_list_checker #(
    parameter int LIST_DEPTH = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    rol_in_if    i_in,
    rol_out_if   i_out,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_hit_count,
    output int   o_bad_slot_count
);
    import rol_pkg::*;

    // Shadow of the list, most recent entry first, and its fill level.
    t_entry      recent [LIST_DEPTH];
    int unsigned held;

    // Result words still owed by the block, oldest first.
    t_out_word   owed_results [$];

    int          mismatches;
    int          result_no;

    // Applies one input word to the shadow list and returns the result it causes.
    function automatic t_out_word apply_list_op(t_in_word w);
        t_out_word r;
        t_entry    moved;
        int        pos;
        int        i;
        bit        found;
        r     = '0;
        found = 1'b0;
        pos   = 0;
        if (w.operation == OP_REMEMBER) begin
            // Search on the key: seconds and icon together.
            for (i = 0; i < int'(held); i++) begin
                if (!found && recent[i].seconds == w.entry_seconds &&
                    recent[i].icon == w.entry_icon) begin
                    found = 1'b1;
                    pos   = i;
                end
            end
            if (found) begin
                moved        = recent[pos];
                moved.melody = w.entry_melody;
                r.was_present = 1'b1;
                o_hit_count++;
            end else begin
                moved.seconds = w.entry_seconds;
                moved.icon    = w.entry_icon;
                moved.melody  = w.entry_melody;
                if (held < LIST_DEPTH) begin
                    held++;
                end
                // On a full list the oldest entry is overwritten by the shift.
                pos = int'(held) - 1;
            end
            for (i = pos; i > 0; i--) begin
                recent[i] = recent[i-1];
            end
            recent[0] = moved;
        end else if (w.slot_index >= held) begin
            // Position at or past the fill level: nothing changes.
            r.status = ST_BAD_SLOT;
            o_bad_slot_count++;
        end else begin
            case (w.operation)
                OP_REPLACE: begin
                    recent[w.slot_index].seconds = w.entry_seconds;
                    recent[w.slot_index].icon    = w.entry_icon;
                    recent[w.slot_index].melody  = w.entry_melody;
                end
                OP_DELETE: begin
                    for (i = int'(w.slot_index); i + 1 < int'(held); i++) begin
                        recent[i] = recent[i+1];
                    end
                    held--;
                end
                default: begin
                    r.read_seconds = recent[w.slot_index].seconds;
                    r.read_icon    = recent[w.slot_index].icon;
                    r.read_melody  = recent[w.slot_index].melody;
                end
            endcase
        end
        r.stored_count = COUNT_W'(held);
        return r;
    endfunction

    // Compare finished words first, then predict for the newly accepted one.
    always @(posedge i_clk) begin
        t_out_word want;
        t_out_word got;
        if (!i_rst_n) begin
            owed_results.delete();
            held             <= 0;
            mismatches       <= 0;
            result_no        <= 0;
            o_hit_count      <= 0;
            o_bad_slot_count <= 0;
            o_pending        <= 0;
            for (int k = 0; k < LIST_DEPTH; k++) begin
                recent[k] <= '0;
            end
        end else begin
            if (i_out.valid && i_out.ready) begin
                got = i_out.data;
                result_no <= result_no + 1;
                if (owed_results.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("result word %0d arrived with nothing expected: %h",
                                 result_no, got);
                    end
                    mismatches <= mismatches + 1;
                end else begin
                    want = owed_results.pop_front();
                    if (got.status !== want.status ||
                        got.was_present !== want.was_present ||
                        got.stored_count !== want.stored_count ||
                        got.read_seconds !== want.read_seconds ||
                        got.read_icon !== want.read_icon ||
                        got.read_melody !== want.read_melody) begin
                        if (mismatches < 10) begin
                            $display({"result word %0d wrong (expected/actual): status %0d/%0d",
                                      " present %0d/%0d count %0d/%0d seconds %h/%h",
                                      " icon %h/%h melody %h/%h"},
                                     result_no, want.status, got.status,
                                     want.was_present, got.was_present,
                                     want.stored_count, got.stored_count,
                                     want.read_seconds, got.read_seconds,
                                     want.read_icon, got.read_icon,
                                     want.read_melody, got.read_melody);
                        end
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                owed_results.push_back(apply_list_op(i_in.data));
            end
            o_pending <= owed_results.size();
        end
    end

    assign o_fail_count = mismatches;

endmodule

// ===== sim/testbench.sv =====
// Top of the preset list testbench: clock, reset, word stimulus, result stall and verdict.
// Depends on rol_pkg, rol_if, the list unit and preset_list_checker.
`timescale 1ns / 1ps

module testbench;
    import rol_pkg::*;

    localparam int DEPTH      = 8;
    localparam int IDLE_LIMIT = 2000;
    localparam int PHASE_LEN  = 255;

    logic i_clk;
    logic i_rst_n;

    rol_in_if  in_ch ();
    rol_out_if out_ch ();

    int  fail_count;
    int  pending;
    int  hit_count;
    int  bad_slot_count;
    int  words_sent;
    bit  src_quiet;
    bit  snk_quiet;

    // Keys reused by remember and replace so that searches find matches.
    t_entry key_pool [16];

    recency_ordered_preset_list_unit #(
        .LIST_DEPTH(DEPTH)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    preset_list_checker #(
        .LIST_DEPTH(DEPTH)
    ) i_list_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in            (in_ch),
        .i_out           (out_ch),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_hit_count     (hit_count),
        .o_bad_slot_count(bad_slot_count)
    );

    // Clock with a 20 ns period.
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_in_word make_word(t_op op, logic [SLOT_W-1:0] slot,
                                           logic [SEC_W-1:0] sec, logic [ICON_W-1:0] icon,
                                           logic [MEL_W-1:0] mel);
        t_in_word w;
        w.operation     = op;
        w.slot_index    = slot;
        w.entry_seconds = sec;
        w.entry_icon    = icon;
        w.entry_melody  = mel;
        return w;
    endfunction

    // Offers one word after a random gap and returns at the edge that takes it.
    task automatic push_word(input t_in_word w);
        int gap;
        gap = src_quiet ? 0 : $urandom_range(0, 4);
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= w;
        do @(posedge i_clk); while (!in_ch.ready);
        words_sent++;
    endtask

    // Holds the sender back until every owed result has come out.
    task automatic drain;
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // Extremes, each operation on an empty and a full list, hits and overflow.
    task automatic run_directed;
        int k;
        push_word(make_word(OP_READ, 3'd0, '0, '0, '0));
        push_word(make_word(OP_DELETE, 3'd0, '0, '0, '0));
        push_word(make_word(OP_REPLACE, 3'd7, '1, '1, '1));
        push_word(make_word(OP_READ, 3'd7, '0, '0, '0));
        push_word(make_word(OP_REMEMBER, 3'd0, '0, '0, '0));
        push_word(make_word(OP_REMEMBER, 3'd7, '1, '1, '1));
        // Hit on the front entry: only the melody changes.
        push_word(make_word(OP_REMEMBER, 3'd0, '1, '1, 8'h5a));
        // Hit one down from the front.
        push_word(make_word(OP_REMEMBER, 3'd0, '0, '0, 8'ha5));
        // Same seconds with another icon, and the other way round, are misses.
        push_word(make_word(OP_REMEMBER, 3'd0, '0, 8'h01, 8'h00));
        push_word(make_word(OP_REMEMBER, 3'd0, 20'h1, 8'h00, 8'h00));
        // Fill the list and push two entries off the end.
        for (k = 2; k < 8; k++) begin
            push_word(make_word(OP_REMEMBER, 3'd0, SEC_W'(20'h100 + k), ICON_W'(k),
                                MEL_W'(k)));
        end
        // Hit on the oldest entry.
        push_word(make_word(OP_REMEMBER, 3'd0, '0, 8'h01, 8'h33));
        push_word(make_word(OP_READ, 3'd7, '0, '0, '0));
        push_word(make_word(OP_READ, 3'd0, '0, '0, '0));
        push_word(make_word(OP_REPLACE, 3'd7, '0, '0, '0));
        push_word(make_word(OP_REPLACE, 3'd0, '1, '1, '1));
        push_word(make_word(OP_DELETE, 3'd7, '0, '0, '0));
        push_word(make_word(OP_DELETE, 3'd0, '0, '0, '0));
        push_word(make_word(OP_DELETE, 3'd3, '0, '0, '0));
        push_word(make_word(OP_READ, 3'd5, '0, '0, '0));
        push_word(make_word(OP_READ, 3'd4, '0, '0, '0));
    endtask

    // Random words with a given share of each operation, in percent.
    task automatic run_phase(input int w_rem, input int w_rep, input int w_del);
        int          n;
        int          pick;
        t_op         op;
        t_entry      key;
        t_in_word    w;
        for (n = 0; n < PHASE_LEN; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < w_rem) begin
                op = OP_REMEMBER;
            end else if (pick < w_rem + w_rep) begin
                op = OP_REPLACE;
            end else if (pick < w_rem + w_rep + w_del) begin
                op = OP_DELETE;
            end else begin
                op = OP_READ;
            end
            if ($urandom_range(0, 99) < 65) begin
                key = key_pool[$urandom_range(0, 15)];
            end else begin
                key.seconds = SEC_W'($urandom());
                key.icon    = ICON_W'($urandom());
            end
            key.melody = MEL_W'($urandom());
            w = make_word(op, SLOT_W'($urandom_range(0, 7)), key.seconds, key.icon,
                          key.melody);
            push_word(w);
        end
    endtask

    // Result side: a random stall before each word, none while snk_quiet is set.
    initial begin
        int stall;
        out_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = snk_quiet ? 0 : $urandom_range(0, 4);
            @(negedge i_clk);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    // Watchdog on cycles in which neither channel moves a word.
    initial begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    // Stimulus and verdict.
    initial begin
        int p;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        i_rst_n     = 1'b0;
        words_sent  = 0;
        src_quiet   = 1'b0;
        snk_quiet   = 1'b0;
        key_pool[0] = '{seconds: '1, icon: '1, melody: '0};
        key_pool[1] = '{seconds: '0, icon: '0, melody: '0};
        for (p = 2; p < 16; p++) begin
            key_pool[p].seconds = SEC_W'($urandom());
            key_pool[p].icon    = ICON_W'($urandom());
            key_pool[p].melody  = '0;
        end
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        drain();

        // Mixed, then delete-heavy, then remember-heavy, then further mixes, with and without idling.
        run_phase(40, 15, 20);
        drain();
        run_phase(20, 10, 50);
        drain();
        src_quiet = 1'b1;
        snk_quiet = 1'b1;
        run_phase(70, 10, 5);
        drain();
        src_quiet = 1'b0;
        snk_quiet = 1'b0;
        run_phase(35, 20, 15);
        drain();
        src_quiet = 1'b1;
        run_phase(30, 10, 35);
        drain();
        src_quiet = 1'b0;
        snk_quiet = 1'b1;
        run_phase(55, 15, 10);
        snk_quiet = 1'b0;

        drain();
        repeat (2 * DEPTH + 10) @(negedge i_clk);

        $display("Run covered %0d words with a list of %0d entries.", words_sent, DEPTH);
        $display("Remember found %0d matches; %0d words named a position past the fill level.",
                 hit_count, bad_slot_count);
        if (fail_count == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== recency_ordered_preset_list_unit.f =====
rtl/rol_pkg.sv
rtl/rol_if.sv
rtl/rol_mem.sv
rtl/recency_ordered_preset_list_unit.sv
sim/preset_list_checker.sv
sim/testbench.sv
